### hw/rtl/event_ring_overwrite_oldest_core_macros.svh
// Assertion macros for the event ring RTL.
`ifndef EVENT_RING_OVERWRITE_OLDEST_CORE_MACROS_SVH
`define EVENT_RING_OVERWRITE_OLDEST_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define ERO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ERO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ERO_ASSERT(lbl, clk, rst_n, prop, msg)
`define ERO_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### hw/rtl/ero_pkg.sv
// Types and constants shared by the event ring modules.
package ero_pkg;

    localparam int MAX_BODY_BYTES = 16;
    localparam int MAX_BODY_BITS  = 8 * MAX_BODY_BYTES;
    localparam int KIND_W         = 16;
    localparam int KICK_EVERY     = 5;
    localparam int KICK_W         = 3;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam logic RK_ACK   = 1'b0;
    localparam logic RK_ENTRY = 1'b1;

    // Input beat
    typedef struct packed {
        logic        opcode;
        logic [15:0] event_kind;
        logic        body_present;
        logic [7:0]  body_length;
        logic [63:0] body_low_word;
        logic [63:0] body_high_word;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic        result_kind;
        logic        dropped_oldest;
        logic [15:0] out_event_kind;
        logic [4:0]  out_body_length;
        logic [63:0] out_body_low;
        logic [63:0] out_body_high;
        logic        watchdog_kick;
        logic [4:0]  occupancy;
        logic        last_of_run;
    } t_out_beat;

    // Controller to datapath commands
    typedef struct packed {
        logic wr_append;
        logic rd_issue;
        logic rd_first;
        logic ld_ack;
        logic ld_entry;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic more;
    } t_dp_stat;

endpackage

### hw/rtl/ero_ram.sv
// Generic simple dual-port RAM with registered read data.
module ero_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ero_ctrl.sv
// Controller state machine: input handshake, drain sequencing, output valid.
module ero_ctrl
    import ero_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_opcode,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    out_free;
    logic    in_ready;
    t_dp_cmd cmd;

    assign out_free = !r_out_valid || i_out_ready;

    // Decode commands and next state
    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = out_free;
                if (i_in_valid && out_free) begin
                    if (i_opcode == OP_APPEND) begin
                        cmd.wr_append = 1'b1;
                        cmd.ld_ack    = 1'b1;
                    end else if (i_stat.more) begin
                        cmd.rd_issue = 1'b1;
                        cmd.rd_first = 1'b1;
                        n_state      = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                // Read data is pending: move it out, then fetch the next slot
                if (out_free) begin
                    cmd.ld_entry = 1'b1;
                    if (i_stat.more) begin
                        cmd.rd_issue = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold output valid until the beat is taken
    always_comb begin
        if (cmd.ld_ack || cmd.ld_entry) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

### hw/rtl/ero_dpath.sv
// Datapath: ring pointers, slot memories, drain sideband and result register.
`include "event_ring_overwrite_oldest_core_macros.svh"

module ero_dpath
    import ero_pkg::*;
#(
    parameter int RING_SLOTS = 32,
    parameter int BODY_BYTES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_beat o_out_data
);

    localparam int PTR_W  = $clog2(RING_SLOTS);
    localparam int LEN_W  = $clog2(BODY_BYTES + 1);
    localparam int META_W = KIND_W + LEN_W;

    logic [PTR_W-1:0]      r_rp;
    logic [PTR_W-1:0]      n_rp;
    logic [PTR_W-1:0]      r_wp;
    logic [PTR_W-1:0]      n_wp;
    logic [PTR_W-1:0]      r_count;
    logic [PTR_W-1:0]      n_count;
    logic [RING_SLOTS-1:0] r_valid;
    logic [RING_SLOTS-1:0] n_valid;
    logic [KICK_W-1:0]     r_kick_cnt;
    logic [KICK_W-1:0]     n_kick_cnt;
    logic                  r_sd_kick;
    logic                  r_sd_last;
    logic [PTR_W-1:0]      r_sd_occ;
    t_out_beat             r_out;

    logic [PTR_W-1:0]      rp_inc;
    logic [PTR_W-1:0]      wp_inc;
    logic                  full;
    logic [LEN_W-1:0]      len_clamp;
    logic [KICK_W-1:0]     kick_use;
    logic                  kick_hit;
    logic [META_W-1:0]     meta_rd;
    logic [MAX_BODY_BITS-1:0] body_in;
    logic [MAX_BODY_BITS-1:0] body_rd;
    logic [PTR_W+4:0]      occ_ack_ext;
    logic [PTR_W+4:0]      occ_ent_ext;
    logic [LEN_W+4:0]      len_ext;
    logic [PTR_W:0]        gap_wrap;
    logic [PTR_W-1:0]      ptr_gap;

    assign rp_inc  = (r_rp == PTR_W'(RING_SLOTS - 1)) ? '0 : r_rp + 1'b1;
    assign wp_inc  = (r_wp == PTR_W'(RING_SLOTS - 1)) ? '0 : r_wp + 1'b1;
    assign full    = (r_count == PTR_W'(RING_SLOTS - 1));
    assign body_in = {i_in_data.body_high_word, i_in_data.body_low_word};

    // Clamp requested length to the slot body size
    always_comb begin
        if (i_in_data.body_length > 8'(BODY_BYTES)) begin
            len_clamp = LEN_W'(BODY_BYTES);
        end else begin
            len_clamp = i_in_data.body_length[LEN_W-1:0];
        end
    end

    // Advance pointers and occupancy
    always_comb begin
        n_rp    = r_rp;
        n_wp    = r_wp;
        n_count = r_count;
        n_valid = r_valid;
        if (i_cmd.wr_append) begin
            n_wp          = wp_inc;
            n_valid[r_wp] = 1'b1;
            if (full) begin
                n_rp = rp_inc;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
        if (i_cmd.rd_issue) begin
            n_rp    = rp_inc;
            n_count = r_count - 1'b1;
        end
    end

    // Count entries within a drain for the watchdog pulse
    assign kick_use   = i_cmd.rd_first ? '0 : r_kick_cnt;
    assign kick_hit   = (kick_use == KICK_W'(KICK_EVERY - 1));
    assign n_kick_cnt = i_cmd.rd_issue ? (kick_hit ? '0 : kick_use + 1'b1) : r_kick_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp       <= '0;
            r_wp       <= '0;
            r_count    <= '0;
            r_valid    <= '0;
            r_kick_cnt <= '0;
        end else begin
            r_rp       <= n_rp;
            r_wp       <= n_wp;
            r_count    <= n_count;
            r_valid    <= n_valid;
            r_kick_cnt <= n_kick_cnt;
        end
    end

    // Carry sideband of the read in flight
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_sd_kick <= kick_hit;
            r_sd_last <= (r_count == PTR_W'(1));
            r_sd_occ  <= r_count - 1'b1;
        end
    end

    // Slot type and length
    ero_ram #(
        .WIDTH (META_W),
        .DEPTH (RING_SLOTS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_append),
        .i_waddr (r_wp),
        .i_wdata ({i_in_data.event_kind, len_clamp}),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rp),
        .o_rdata (meta_rd)
    );

    // Slot body, one RAM per byte lane; a never-written slot gets zeros in
    // the lanes that the append leaves alone
    for (genvar b = 0; b < MAX_BODY_BYTES; b++) begin : g_lane
        if (b < BODY_BYTES) begin : g_ram
            logic       sel;
            logic       we;
            logic [7:0] wdata;

            assign sel   = i_in_data.body_present && (LEN_W'(b) < len_clamp);
            assign we    = i_cmd.wr_append && (!r_valid[r_wp] || sel);
            assign wdata = sel ? body_in[8*b +: 8] : 8'h00;

            ero_ram #(
                .WIDTH (8),
                .DEPTH (RING_SLOTS)
            ) u_body_ram (
                .i_clk   (i_clk),
                .i_we    (we),
                .i_waddr (r_wp),
                .i_wdata (wdata),
                .i_re    (i_cmd.rd_issue),
                .i_raddr (r_rp),
                .o_rdata (body_rd[8*b +: 8])
            );
        end else begin : g_zero
            assign body_rd[8*b +: 8] = 8'h00;
        end
    end

    assign occ_ack_ext = {5'b0, n_count};
    assign occ_ent_ext = {5'b0, r_sd_occ};
    assign len_ext     = {5'b0, meta_rd[LEN_W-1:0]};

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_ack) begin
            r_out.result_kind     <= RK_ACK;
            r_out.dropped_oldest  <= full;
            r_out.out_event_kind  <= '0;
            r_out.out_body_length <= '0;
            r_out.out_body_low    <= '0;
            r_out.out_body_high   <= '0;
            r_out.watchdog_kick   <= 1'b0;
            r_out.occupancy       <= occ_ack_ext[4:0];
            r_out.last_of_run     <= 1'b1;
        end else if (i_cmd.ld_entry) begin
            r_out.result_kind     <= RK_ENTRY;
            r_out.dropped_oldest  <= 1'b0;
            r_out.out_event_kind  <= meta_rd[META_W-1:LEN_W];
            r_out.out_body_length <= len_ext[4:0];
            r_out.out_body_low    <= body_rd[63:0];
            r_out.out_body_high   <= body_rd[127:64];
            r_out.watchdog_kick   <= r_sd_kick;
            r_out.occupancy       <= occ_ent_ext[4:0];
            r_out.last_of_run     <= r_sd_last;
        end
    end

    assign o_stat.more = (r_count != '0);
    assign o_out_data  = r_out;

    // Pointer distance, for checking the occupancy counter
    assign gap_wrap = {1'b0, r_wp} + (PTR_W + 1)'(RING_SLOTS) - {1'b0, r_rp};
    assign ptr_gap  = (r_wp >= r_rp) ? (r_wp - r_rp) : gap_wrap[PTR_W-1:0];

    `ERO_ASSERT(a_no_read_when_empty, i_clk, i_rst_n, i_cmd.rd_issue |-> r_count != '0, "read issued on empty ring")
    `ERO_ASSERT(a_single_ring_op, i_clk, i_rst_n, !(i_cmd.wr_append && i_cmd.rd_issue), "append and drain read together")
    `ERO_ASSERT(a_drop_stays_full, i_clk, i_rst_n, i_cmd.wr_append && full |=> full, "overwriting append left ring not full")
    `ERO_ASSERT(a_count_tracks_ptrs, i_clk, i_rst_n, r_count == ptr_gap, "occupancy disagrees with pointers")

endmodule

### hw/rtl/event_ring_overwrite_oldest_core.sv
// An append's acknowledgement is valid the cycle after its input beat.
// A drain's first entry passes the slot RAM read register, then the result
// register; then one entry per cycle while results are taken, set by the
// single slot read port. No new beat is taken until a drain has ended.
// Reset: pointers, occupancy and per-slot written flags clear synchronously.
// Unwritten body lanes read as zero; no memory clearing pass is needed.
module event_ring_overwrite_oldest_core
    import ero_pkg::*;
#(
    parameter int RING_SLOTS = 32,
    parameter int BODY_BYTES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequence appends and drains
    ero_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_in_data.opcode),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Store slots and build result beats
    ero_dpath #(
        .RING_SLOTS (RING_SLOTS),
        .BODY_BYTES (BODY_BYTES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule
